// ===== rtl/core/etsf_pkg.sv =====
`default_nettype none
package etsf_pkg;

  // Message tag that marks an encoder item
  localparam logic [7:0] MSG_TAG = 8'h42;

  // Fixed-point trig constants, Q30
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  // Taylor series divisors, applied in Horner order
  localparam int HORNER_STEPS = 6;
  typedef logic [7:0] horner_div_t [0:HORNER_STEPS-1];
  localparam horner_div_t HORNER_DIV = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STIFFNESS   = 3'd0,
    REG_TOP_LINK    = 3'd1,
    REG_BOTTOM_LINK = 3'd2,
    REG_OFFSET      = 3'd3,
    REG_REST        = 3'd4
  } cfg_reg_t;

  // Register reset values
  localparam logic [15:0] RST_STIFFNESS   = 16'd5000;
  localparam logic [15:0] RST_TOP_LINK    = 16'd3277;
  localparam logic [15:0] RST_BOTTOM_LINK = 16'd4260;
  localparam logic [15:0] RST_OFFSET      = 16'd655;
  localparam logic [15:0] RST_REST        = 16'd4082;

  // Width of the root argument and of its square root
  localparam int ARG_W  = 52;
  localparam int ROOT_W = ARG_W / 2;

endpackage
`default_nettype wire

// ===== rtl/core/encoder_to_spring_force.sv =====
`default_nettype none
// Channel  | Signals                              | Moves
// ---------+--------------------------------------+------------------------------
// in       | in_valid, in_ready                   | tag_byte, encoder_count
// out      | out_valid, out_ready                 | force_value, compression_value
// cfg      | cfg_we (no wait)                     | cfg_index, cfg_data
//
// One item per cycle while no result is held. The pipeline holds the phase divide
// (5 stages), the six Horner steps of the cosine (21) and the root, one bit per stage (26).
// Items with a tag other than 0x42 are taken but give no result.
// Reset clears all valid bits and loads the register defaults.
// A held result stalls the whole pipeline in place; nothing is lost.
module encoder_to_spring_force #(
  parameter int COUNTS_PER_REV = 1999,
  parameter int COS_TABLE_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     tag_byte,
  input  wire logic signed [31:0]             encoder_count,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [23:0]                  force_value,
  output logic signed [15:0]                  compression_value,
  input  wire logic                           cfg_we,
  input  wire logic [etsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data
);
  import etsf_pkg::*;

  // config registers
  logic [15:0] stiffness, top_link, bottom_link, offset_len, rest_len;
  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness   <= RST_STIFFNESS;
      top_link    <= RST_TOP_LINK;
      bottom_link <= RST_BOTTOM_LINK;
      offset_len  <= RST_OFFSET;
      rest_len    <= RST_REST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STIFFNESS:   stiffness   <= cfg_data;
        REG_TOP_LINK:    top_link    <= cfg_data;
        REG_BOTTOM_LINK: bottom_link <= cfg_data;
        REG_OFFSET:      offset_len  <= cfg_data;
        REG_REST:        rest_len    <= cfg_data;
        default: ;
      endcase
    end
  end

  // terms that depend on config only, settled long before an item needs them
  logic [31:0] sq_t, sq_b, sq_o, tb;
  logic signed [33:0] base;
  logic [32:0] tb2;
  always_ff @(posedge clk) begin
    sq_t <= top_link * top_link;
    sq_b <= bottom_link * bottom_link;
    sq_o <= offset_len * offset_len;
    tb   <= top_link * bottom_link;
    base <= $signed({2'b00, sq_t}) + $signed({2'b00, sq_b}) - $signed({2'b00, sq_o});
    tb2  <= {tb, 1'b0};
  end

  // whole pipeline advances unless a result is held
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic ph_vld, cs_vld;
  logic [COS_TABLE_BITS-1:0] phase;
  logic signed [17:0] cos16;

  etsf_phase #(.CPR(COUNTS_PER_REV), .TB(COS_TABLE_BITS)) u_phase (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(in_valid && tag_byte == MSG_TAG),
    .count(encoder_count), .out_vld(ph_vld), .phase(phase)
  );

  etsf_cos #(.TB(COS_TABLE_BITS)) u_cos (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(ph_vld), .phase(phase), .out_vld(cs_vld), .cos16(cos16)
  );

  // root argument: base * 2^16 - 2*top*bottom*cos, clamped at zero
  logic vA, vB;
  logic signed [51:0] mulA;
  logic [ARG_W-1:0]   argB;
  logic signed [51:0] argw;
  assign argw = $signed({{2{base[33]}}, base, 16'd0}) - mulA;

  // length, compression and force
  logic              sq_vld, vC, vD;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W:0]   rsum;
  logic signed [19:0] compC, compD;
  logic signed [36:0] prodD;
  logic signed [28:0] fsh;
  assign rsum = {1'b0, root} + (ROOT_W+1)'(128);
  assign fsh  = prodD[36:8];

  etsf_isqrt #(.AW(ARG_W)) u_isqrt (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(vB), .arg(argB), .out_vld(sq_vld), .root(root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vA <= 1'b0; vB <= 1'b0; vC <= 1'b0; vD <= 1'b0; out_valid <= 1'b0;
    end else if (adv) begin
      vA <= cs_vld; vB <= vA; vC <= sq_vld; vD <= vC; out_valid <= vD;
    end
    if (adv) begin
      mulA  <= $signed({1'b0, tb2}) * cos16;
      argB  <= argw[51] ? '0 : argw;
      compC <= $signed({1'b0, rsum[ROOT_W:8]}) - $signed({4'd0, rest_len});
      compD <= compC;
      prodD <= $signed({1'b0, stiffness}) * compC + 37'sd128;
      // saturate both fields
      if (fsh > 29'sd8388607)       force_value <= 24'sh7FFFFF;
      else if (fsh < -29'sd8388608) force_value <= 24'sh800000;
      else                          force_value <= fsh[23:0];
      if (compD > 20'sd32767)       compression_value <= 16'sh7FFF;
      else if (compD < -20'sd32768) compression_value <= 16'sh8000;
      else                          compression_value <= compD[15:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/etsf_phase.sv =====
`default_nettype none
// Count modulo counts-per-rev, then scaled to a table phase.
// Both divisions by the constant use a floor reciprocal and one correction.
module etsf_phase #(
  parameter int CPR = 1999,
  parameter int TB  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_vld,
  input  wire logic signed [31:0] count,
  output logic                   out_vld,
  output logic [TB-1:0]          phase
);

  localparam int CW  = $clog2(CPR);
  localparam int MW  = 33 - CW;
  localparam int MPW = TB + 33 - CW;
  localparam logic [MW-1:0]  RECIP   = MW'((64'd1 << 32) / CPR);
  localparam logic [MPW-1:0] RECIP_P = MPW'((64'd1 << (TB + 32)) / CPR);
  localparam logic [CW:0]    CPR_K   = (CW+1)'(CPR);
  localparam longint         OFF_L   = (CPR - ((64'd1 << 31) % CPR)) % CPR;
  localparam logic [CW:0]    OFF_K   = (CW+1)'(OFF_L);

  logic              v1, v2, v3, v4;
  logic [31:0]       u1;
  logic [31+MW:0]    qm1;
  logic [CW-1:0]     ru2, r3, r4;
  logic [CW+MPW-1:0] pp4;

  // stage 2 remainder of the offset count
  logic [MW-1:0]   q0_2;
  logic [MW+CW:0]  qc2;
  logic [32:0]     rem2;
  logic [CW:0]     rlo2;
  logic [CW-1:0]   ru2_next;
  assign q0_2 = qm1[31+MW:32];
  assign qc2  = q0_2 * CPR_K;
  assign rem2 = {1'b0, u1} - qc2[32:0];
  assign rlo2 = rem2[CW:0];
  assign ru2_next = (rlo2 >= CPR_K) ? CW'(rlo2 - CPR_K) : rlo2[CW-1:0];

  // stage 3 undo the 2^31 offset
  logic [CW:0]   s3;
  logic [CW-1:0] r3_next;
  assign s3 = {1'b0, ru2} + OFF_K;
  assign r3_next = (s3 >= CPR_K) ? CW'(s3 - CPR_K) : s3[CW-1:0];

  // stage 5 phase quotient with correction
  logic [CW+MPW-33:0] q5;
  logic [CW+MPW:0]    qc5;
  logic [CW+TB:0]     rem5;
  logic [CW+MPW-33:0] p5;
  assign q5   = pp4[CW+MPW-1:32];
  assign qc5  = q5 * CPR_K;
  assign rem5 = {1'b0, r4, {TB{1'b0}}} - qc5[CW+TB:0];
  assign p5   = q5 + (CW+MPW-32)'(rem5 >= (CW+TB+1)'(CPR));

  // count offset to unsigned, reciprocal multiplies, remainders
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; out_vld <= 1'b0;
    end else if (en) begin
      v1 <= in_vld; v2 <= v1; v3 <= v2; v4 <= v3; out_vld <= v4;
    end
    if (en) begin
      u1    <= {~count[31], count[30:0]};
      qm1   <= {~count[31], count[30:0]} * RECIP;
      ru2   <= ru2_next;
      r3    <= r3_next;
      r4    <= r3;
      pp4   <= r3 * RECIP_P;
      phase <= p5[TB-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/etsf_horner_step.sv =====
`default_nettype none
// One Horner step: t_out = 2^30 - floor(x2 * t_in / (DIV * 2^30)).
// Multiply, reciprocal divide, correct: three register stages.
module etsf_horner_step #(
  parameter int DIV = 132
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_vld,
  input  wire logic [31:0]        x2_in,
  input  wire logic [30:0]        t_in,
  input  wire logic               neg_in,
  output logic                    out_vld,
  output logic [31:0]             x2_out,
  output logic signed [32:0]      t_out,
  output logic                    neg_out
);
  import etsf_pkg::*;

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);
  localparam logic [7:0]  DIV_K = 8'(DIV);

  logic        va, vb;
  logic [31:0] x2a, x2b;
  logic        nga, ngb;
  logic [62:0] pa;
  logic [31:0] vqb;
  logic [63:0] qb;

  // correction of the reciprocal quotient
  logic [31:0] q0;
  logic [39:0] qc, rem;
  logic [32:0] q;
  assign q0  = qb[63:32];
  assign qc  = q0 * DIV_K;
  assign rem = {8'd0, vqb} - qc;
  assign q   = {1'b0, q0} + 33'(rem >= 40'(DIV_K));

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; out_vld <= 1'b0;
    end else if (en) begin
      va <= in_vld; vb <= va; out_vld <= vb;
    end
    if (en) begin
      pa      <= x2_in * t_in;
      x2a     <= x2_in;
      nga     <= neg_in;
      vqb     <= pa[61:30];
      qb      <= pa[61:30] * RECIP;
      x2b     <= x2a;
      ngb     <= nga;
      t_out   <= $signed({2'b00, ONE_Q30}) - $signed(q);
      x2_out  <= x2b;
      neg_out <= ngb;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/etsf_cos.sv =====
`default_nettype none
// Cosine of the table phase in signed Q1.16: quadrant fold, angle in Q30,
// square, Taylor series by a chain of Horner steps, clamp and round.
module etsf_cos #(
  parameter int TB = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire logic [TB-1:0] phase,
  output logic               out_vld,
  output logic signed [17:0] cos16
);
  import etsf_pkg::*;

  localparam int QW = TB - 2;

  logic          v6, v7;
  logic          ng6, ng7;
  logic [QW+31:0] xp6;
  logic [61:0]    xx7;

  // quadrant fold
  logic [1:0]  quad;
  logic [QW:0] uu;
  assign quad = phase[TB-1:TB-2];
  assign uu = quad[0] ? ((QW+1)'(1) << QW) - {1'b0, phase[QW-1:0]}
                      : {1'b0, phase[QW-1:0]};

  logic [30:0] x7;
  assign x7 = xp6[QW+30:QW];

  // Horner chain
  logic              hv  [0:HORNER_STEPS];
  logic [31:0]       hx2 [0:HORNER_STEPS];
  logic signed [32:0] ht [0:HORNER_STEPS];
  logic              hng [0:HORNER_STEPS];

  assign hv[0]  = v7;
  assign hx2[0] = xx7[61:30];
  assign ht[0]  = $signed({2'b00, ONE_Q30});
  assign hng[0] = ng7;

  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
    etsf_horner_step #(.DIV(int'(HORNER_DIV[i]))) u_step (
      .clk(clk), .rst(rst), .en(en),
      .in_vld(hv[i]), .x2_in(hx2[i]), .t_in(ht[i][30:0]), .neg_in(hng[i]),
      .out_vld(hv[i+1]), .x2_out(hx2[i+1]), .t_out(ht[i+1]), .neg_out(hng[i+1])
    );
  end

  // clamp to [0, 1.0] and round to Q16
  logic [30:0] tc;
  logic [30:0] tr;
  logic [16:0] mag;
  assign tc  = ht[HORNER_STEPS][32] ? 31'd0 :
               (ht[HORNER_STEPS] > $signed({2'b00, ONE_Q30})) ? ONE_Q30 :
               ht[HORNER_STEPS][30:0];
  assign tr  = tc + 31'd8192;
  assign mag = tr[30:14];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0; v7 <= 1'b0; out_vld <= 1'b0;
    end else if (en) begin
      v6 <= in_vld; v7 <= v6; out_vld <= hv[HORNER_STEPS];
    end
    if (en) begin
      xp6   <= uu * HALF_PI_Q30;
      ng6   <= quad[1] ^ quad[0];
      xx7   <= x7 * x7;
      ng7   <= ng6;
      cos16 <= hng[HORNER_STEPS] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/etsf_isqrt.sv =====
`default_nettype none
// Integer square root, one result bit per register stage.
module etsf_isqrt #(
  parameter int AW = 52
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_vld,
  input  wire logic [AW-1:0]   arg,
  output logic                 out_vld,
  output logic [AW/2-1:0]      root
);

  localparam int RW = AW / 2;

  logic          sv   [1:RW];
  logic [RW:0]   srem [1:RW];
  logic [RW-1:0] sroot[1:RW];
  logic [AW-1:0] sa   [1:RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic          vi;
    logic [RW:0]   remi;
    logic [RW-1:0] rooti;
    logic [AW-1:0] ai;
    logic [RW+2:0] remsh, trial, diff;
    logic          take;

    if (i == 0) begin : g_first
      assign vi = in_vld; assign remi = '0; assign rooti = '0; assign ai = arg;
    end else begin : g_rest
      assign vi = sv[i]; assign remi = srem[i]; assign rooti = sroot[i]; assign ai = sa[i];
    end

    // try appending a one bit to the root
    assign remsh = {remi, ai[AW-1:AW-2]};
    assign trial = {1'b0, rooti, 2'b01};
    assign take  = remsh >= trial;
    assign diff  = remsh - trial;

    always_ff @(posedge clk) begin
      if (rst) sv[i+1] <= 1'b0;
      else if (en) sv[i+1] <= vi;
      if (en) begin
        srem[i+1]  <= take ? diff[RW:0] : remsh[RW:0];
        sroot[i+1] <= {rooti[RW-2:0], take};
        sa[i+1]    <= ai << 2;
      end
    end
  end

  assign out_vld = sv[RW];
  assign root    = sroot[RW];

endmodule
`default_nettype wire

// ===== rtl/core/etsf_checker.sv =====
`default_nettype none
module etsf_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [23:0] force_value,
  input wire logic signed [15:0] compression_value
);

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(force_value)
                                && $stable(compression_value))
    else $error("held result changed");

  // input is taken whenever the output stage is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // force follows the sign of the compression
  a_sign_neg: assert property (@(posedge clk) disable iff (rst)
    out_valid && compression_value < 0 |-> force_value <= 0)
    else $error("positive force on negative compression");

  a_sign_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && compression_value > 0 |-> force_value >= 0)
    else $error("negative force on positive compression");

endmodule

bind encoder_to_spring_force etsf_checker u_etsf_checker (.*);
`default_nettype wire
